// ===== hdl/sgr_pkg.sv =====
// ----------------------------------------------------------------------------
// sgr_pkg
// types and codes shared by the sgr attribute decoder and its checker
// ----------------------------------------------------------------------------
package sgr_pkg;

    localparam int unsigned PARAM_W = 16;
    localparam int unsigned COLOUR_W = 8;
    localparam int unsigned ATTR_W = 5;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_BG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_ATTR = 2'd2;

    // reset values of the configuration registers
    localparam logic [COLOUR_W-1:0] RST_DEF_FG = 8'd7;
    localparam logic [COLOUR_W-1:0] RST_DEF_BG = 8'd0;
    localparam logic [ATTR_W-1:0] RST_DEF_ATTR = 5'd0;

    // attribute bit positions
    localparam int unsigned ATTR_BOLD = 0;
    localparam int unsigned ATTR_ITALIC = 1;
    localparam int unsigned ATTR_UNDERLINE = 2;
    localparam int unsigned ATTR_BLINK = 3;
    localparam int unsigned ATTR_REVERSE = 4;

    // sgr codes with a fixed meaning
    localparam logic [PARAM_W-1:0] SGR_RESET = 16'd0;
    localparam logic [PARAM_W-1:0] SGR_BOLD = 16'd1;
    localparam logic [PARAM_W-1:0] SGR_ITALIC = 16'd3;
    localparam logic [PARAM_W-1:0] SGR_UNDERLINE = 16'd4;
    localparam logic [PARAM_W-1:0] SGR_BLINK_SLOW = 16'd5;
    localparam logic [PARAM_W-1:0] SGR_BLINK_FAST = 16'd6;
    localparam logic [PARAM_W-1:0] SGR_REVERSE = 16'd7;
    localparam logic [PARAM_W-1:0] SGR_NO_BOLD_A = 16'd21;
    localparam logic [PARAM_W-1:0] SGR_NO_BOLD_B = 16'd22;
    localparam logic [PARAM_W-1:0] SGR_NO_ITALIC = 16'd23;
    localparam logic [PARAM_W-1:0] SGR_NO_UNDERLINE = 16'd24;
    localparam logic [PARAM_W-1:0] SGR_NO_BLINK_A = 16'd25;
    localparam logic [PARAM_W-1:0] SGR_NO_BLINK_B = 16'd26;
    localparam logic [PARAM_W-1:0] SGR_NO_REVERSE = 16'd27;
    localparam logic [PARAM_W-1:0] SGR_FG_EXT = 16'd38;
    localparam logic [PARAM_W-1:0] SGR_FG_DEFAULT = 16'd39;
    localparam logic [PARAM_W-1:0] SGR_BG_EXT = 16'd48;
    localparam logic [PARAM_W-1:0] SGR_BG_DEFAULT = 16'd49;
    localparam logic [PARAM_W-1:0] SGR_EXT_PALETTE = 16'd5;

    // colour range bases
    localparam logic [PARAM_W-1:0] SGR_FG_BASE = 16'd30;
    localparam logic [PARAM_W-1:0] SGR_BG_BASE = 16'd40;
    localparam logic [PARAM_W-1:0] SGR_FG_BRIGHT = 16'd90;
    localparam logic [PARAM_W-1:0] SGR_BG_BRIGHT = 16'd100;
    localparam logic [PARAM_W-1:0] BRIGHT_OFFSET = 16'd8;
    localparam logic [7:0] DIRECT_FG_PAGE = 8'd1;  // 256..511
    localparam logic [7:0] DIRECT_BG_PAGE = 8'd2;  // 512..767

    typedef enum logic [2:0] {
        EXT_IDLE,
        EXT_FG_SEL,
        EXT_BG_SEL,
        EXT_FG_IDX,
        EXT_BG_IDX
    } t_ext_state;

    typedef struct packed {
        logic [PARAM_W-1:0] param_value;
        logic last_param;
    } t_sgr_in;

    typedef struct packed {
        logic [COLOUR_W-1:0] foreground;
        logic [COLOUR_W-1:0] background;
        logic [ATTR_W-1:0] attributes;
    } t_sgr_out;

endpackage

// ===== hdl/sgr_attribute_decoder.sv =====
// ----------------------------------------------------------------------------
// sgr_attribute_decoder
// ansi sgr parameter decoder keeping the current colours and attribute bits
// ----------------------------------------------------------------------------
// One sgr parameter enters per item, with a flag on the last parameter of a
// sequence, and every item returns the rendition that holds after it:
// foreground index, background index and five attribute bits (bold, italic,
// underline, blink, reverse). The block takes one item every clock cycle while
// its output register is not stalled, and shows its result in the cycle after
// acceptance; the rendition and the pending 38/48 extended-colour state sit in
// registers beside the output register, updated in the cycle the item is taken.
// The result sits in an output register, so a new item is taken whenever
// that register is empty or is being emptied in the same cycle; only a
// stalled, full output register stalls the input. Code 0 restores the
// default registers, 39 and 49 restore the default foreground and
// background, 38;5;n and 48;5;n select a palette index (n of 256 or more is
// swallowed). The last-parameter flag always drops any pending extended form,
// so nothing carries into the next sequence. The user must write defaults
// through the plain write port only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module sgr_attribute_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [sgr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sgr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // parameter items in
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sgr_pkg::t_sgr_in                    i_in_data,
    // rendition items out
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sgr_pkg::t_sgr_out                   o_out_data
);

    // default registers
    logic [sgr_pkg::COLOUR_W-1:0] r_def_fg;
    logic [sgr_pkg::COLOUR_W-1:0] r_def_bg;
    logic [sgr_pkg::ATTR_W-1:0]   r_def_attr;

    // rendition state
    logic [sgr_pkg::COLOUR_W-1:0] r_fg, n_fg;
    logic [sgr_pkg::COLOUR_W-1:0] r_bg, n_bg;
    logic [sgr_pkg::ATTR_W-1:0]   r_attr, n_attr;
    sgr_pkg::t_ext_state          r_ext, n_ext;

    // output register
    logic                         r_out_valid;
    sgr_pkg::t_sgr_out            r_out_data;

    logic                         in_accept;
    logic                         decode_plain;
    logic [sgr_pkg::PARAM_W-1:0]  v;

    // full output register that is not drained blocks the input
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign v          = i_in_data.param_value;

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_fg   <= sgr_pkg::RST_DEF_FG;
            r_def_bg   <= sgr_pkg::RST_DEF_BG;
            r_def_attr <= sgr_pkg::RST_DEF_ATTR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sgr_pkg::CFG_DEF_FG: begin
                    r_def_fg <= i_cfg_data;
                end
                sgr_pkg::CFG_DEF_BG: begin
                    r_def_bg <= i_cfg_data;
                end
                sgr_pkg::CFG_DEF_ATTR: begin
                    r_def_attr <= i_cfg_data[sgr_pkg::ATTR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // next rendition for the item at the input
    always_comb begin
        n_fg   = r_fg;
        n_bg   = r_bg;
        n_attr = r_attr;
        n_ext  = sgr_pkg::EXT_IDLE;
        decode_plain = 1'b0;

        case (r_ext)
            sgr_pkg::EXT_FG_SEL, sgr_pkg::EXT_BG_SEL: begin
                // 38;5 / 48;5 moves on to the index, anything else is a code
                if (v == sgr_pkg::SGR_EXT_PALETTE && !i_in_data.last_param) begin
                    n_ext = (r_ext == sgr_pkg::EXT_FG_SEL) ? sgr_pkg::EXT_FG_IDX
                                                           : sgr_pkg::EXT_BG_IDX;
                end else begin
                    decode_plain = 1'b1;
                end
            end
            sgr_pkg::EXT_FG_IDX: begin
                if (v[15:8] == 8'd0) begin
                    n_fg = v[7:0];
                end
            end
            sgr_pkg::EXT_BG_IDX: begin
                if (v[15:8] == 8'd0) begin
                    n_bg = v[7:0];
                end
            end
            default: begin
                decode_plain = 1'b1;
            end
        endcase

        if (decode_plain) begin
            case (v)
                sgr_pkg::SGR_RESET: begin
                    n_fg   = r_def_fg;
                    n_bg   = r_def_bg;
                    n_attr = r_def_attr;
                end
                sgr_pkg::SGR_BOLD:         n_attr[sgr_pkg::ATTR_BOLD] = 1'b1;
                sgr_pkg::SGR_ITALIC:       n_attr[sgr_pkg::ATTR_ITALIC] = 1'b1;
                sgr_pkg::SGR_UNDERLINE:    n_attr[sgr_pkg::ATTR_UNDERLINE] = 1'b1;
                sgr_pkg::SGR_BLINK_SLOW,
                sgr_pkg::SGR_BLINK_FAST:   n_attr[sgr_pkg::ATTR_BLINK] = 1'b1;
                sgr_pkg::SGR_REVERSE:      n_attr[sgr_pkg::ATTR_REVERSE] = 1'b1;
                sgr_pkg::SGR_NO_BOLD_A,
                sgr_pkg::SGR_NO_BOLD_B:    n_attr[sgr_pkg::ATTR_BOLD] = 1'b0;
                sgr_pkg::SGR_NO_ITALIC:    n_attr[sgr_pkg::ATTR_ITALIC] = 1'b0;
                sgr_pkg::SGR_NO_UNDERLINE: n_attr[sgr_pkg::ATTR_UNDERLINE] = 1'b0;
                sgr_pkg::SGR_NO_BLINK_A,
                sgr_pkg::SGR_NO_BLINK_B:   n_attr[sgr_pkg::ATTR_BLINK] = 1'b0;
                sgr_pkg::SGR_NO_REVERSE:   n_attr[sgr_pkg::ATTR_REVERSE] = 1'b0;
                sgr_pkg::SGR_FG_EXT:       n_ext = sgr_pkg::EXT_FG_SEL;
                sgr_pkg::SGR_FG_DEFAULT:   n_fg = r_def_fg;
                sgr_pkg::SGR_BG_EXT:       n_ext = sgr_pkg::EXT_BG_SEL;
                sgr_pkg::SGR_BG_DEFAULT:   n_bg = r_def_bg;
                default: begin
                    // colour ranges; everything else leaves the state alone
                    if (v >= sgr_pkg::SGR_FG_BASE
                            && v < sgr_pkg::SGR_FG_BASE + sgr_pkg::BRIGHT_OFFSET) begin
                        n_fg = 8'(v - sgr_pkg::SGR_FG_BASE);
                    end else if (v >= sgr_pkg::SGR_BG_BASE
                            && v < sgr_pkg::SGR_BG_BASE + sgr_pkg::BRIGHT_OFFSET) begin
                        n_bg = 8'(v - sgr_pkg::SGR_BG_BASE);
                    end else if (v >= sgr_pkg::SGR_FG_BRIGHT
                            && v < sgr_pkg::SGR_FG_BRIGHT + sgr_pkg::BRIGHT_OFFSET) begin
                        n_fg = 8'(v - sgr_pkg::SGR_FG_BRIGHT + sgr_pkg::BRIGHT_OFFSET);
                    end else if (v >= sgr_pkg::SGR_BG_BRIGHT
                            && v < sgr_pkg::SGR_BG_BRIGHT + sgr_pkg::BRIGHT_OFFSET) begin
                        n_bg = 8'(v - sgr_pkg::SGR_BG_BRIGHT + sgr_pkg::BRIGHT_OFFSET);
                    end else if (v[15:8] == sgr_pkg::DIRECT_FG_PAGE) begin
                        n_fg = v[7:0];
                    end else if (v[15:8] == sgr_pkg::DIRECT_BG_PAGE) begin
                        n_bg = v[7:0];
                    end
                end
            endcase
        end

        // end of sequence drops any pending extended form
        if (i_in_data.last_param) begin
            n_ext = sgr_pkg::EXT_IDLE;
        end
    end

    // rendition state, updated on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg   <= sgr_pkg::RST_DEF_FG;
            r_bg   <= sgr_pkg::RST_DEF_BG;
            r_attr <= sgr_pkg::RST_DEF_ATTR;
            r_ext  <= sgr_pkg::EXT_IDLE;
        end else if (in_accept) begin
            r_fg   <= n_fg;
            r_bg   <= n_bg;
            r_attr <= n_attr;
            r_ext  <= n_ext;
        end
    end

    // output register: loaded on accept, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data.foreground <= n_fg;
            r_out_data.background <= n_bg;
            r_out_data.attributes <= n_attr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hdl/sgr_chk.sv =====
// ----------------------------------------------------------------------------
// sgr_chk
// port-level checks for the sgr attribute decoder
// ----------------------------------------------------------------------------
module sgr_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  sgr_pkg::t_sgr_out           i_out_data
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // input stalls only behind a full, stalled output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> i_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // every accepted item shows a result next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_out_valid)
        else $error("accepted item gave no result");

    // a taken result with nothing new behind it empties the output
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_stall && !i_in_valid |=> !i_out_valid)
        else $error("result repeated");

endmodule

bind sgr_attribute_decoder sgr_chk u_sgr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
